@@ rtl/sorted_priority_list_core_assert.svh @@
// ----------------------------------------------------------------------------
// sorted_priority_list_core_assert.svh
// Assertion macros shared by the sorted priority list RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n
// is low; the enclosing module must provide both names.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_LIST_CORE_ASSERT_SVH
`define SORTED_PRIORITY_LIST_CORE_ASSERT_SVH

// Check that a condition holds at every sampled edge outside reset.
`define SPL_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sorted priority list: invariant violated");

// Check a consequence in the same cycle as its trigger.
`define SPL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority list: same-cycle check failed");

// Check a consequence in the cycle after its trigger.
`define SPL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority list: next-cycle check failed");

`endif

@@ rtl/spl_pkg.sv @@
// ----------------------------------------------------------------------------
// spl_pkg
// Shared widths, command and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package spl_pkg;

    // Fixed field widths of the transaction ports
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Broadcast from the list control to every cell
    typedef struct packed {
        logic                     shift_en;  // accepted insert that fits
        logic signed [PRIO_W-1:0] prio;      // priority of the new entry
    } spl_cell_ctrl_t;

endpackage

@@ rtl/spl_cell.sv @@
// ----------------------------------------------------------------------------
// spl_cell
// One position of the sorted list: holds an entry, compares it with the
// incoming priority and, on insert, keeps, loads the new entry or takes the
// entry of its front neighbor.
// ----------------------------------------------------------------------------
module spl_cell #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                               clk,
    input  spl_pkg::spl_cell_ctrl_t            ctrl,
    input  logic [PAYLOAD_BITS-1:0]            new_payload,
    input  logic                               occupied,
    input  logic                               prev_ahead,
    input  logic [PAYLOAD_BITS-1:0]            prev_payload,
    input  logic signed [spl_pkg::PRIO_W-1:0]  prev_prio,
    output logic                               ahead,
    output logic [PAYLOAD_BITS-1:0]            payload,
    output logic signed [spl_pkg::PRIO_W-1:0]  prio
);

    logic [PAYLOAD_BITS-1:0]           payload_reg;
    logic [PAYLOAD_BITS-1:0]           payload_next;
    logic signed [spl_pkg::PRIO_W-1:0] prio_reg;
    logic signed [spl_pkg::PRIO_W-1:0] prio_next;
    logic                              load_en;

    // Stay in place while the stored entry outranks the new one
    assign ahead   = occupied && ($signed(prio_reg) > $signed(ctrl.prio));
    assign load_en = ctrl.shift_en && !ahead;

    // Load the new entry at the insert point, shift back behind it
    always_comb
    begin
        if (prev_ahead)
        begin
            payload_next = new_payload;
            prio_next    = ctrl.prio;
        end
        else
        begin
            payload_next = prev_payload;
            prio_next    = prev_prio;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            payload_reg <= payload_next;
            prio_reg    <= prio_next;
        end
    end

    assign payload = payload_reg;
    assign prio    = prio_reg;

endmodule

@@ rtl/sorted_priority_list_core.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_list_core
// Bounded list of (payload, priority) entries kept in descending priority
// order in a row of cells; inserts by priority and reads by position.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake         | Fields
//  --------+-----------+-------------------+--------------------------------------
//  in      | input     | in_valid/in_stall | cmd, item_value, priority_in, read_index
//  out     | output    | out_valid/out_stall | value_out, priority_out, count_out, status
//
//  One transaction per cycle while in_stall is low; its result is registered and
//  appears in the cycle after acceptance. All cells compare against the new
//  priority at once and shift in the same cycle.
//  Reset clears the entry count and the output valid; entry storage is not reset.
//  in_stall rises only while a result is held and out_stall is high.
//
module sorted_priority_list_core #(
    parameter int CAPACITY     = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic [spl_pkg::VALUE_W-1:0]         item_value,
    input  logic signed [spl_pkg::PRIO_W-1:0]   priority_in,
    input  logic [spl_pkg::INDEX_W-1:0]         read_index,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [spl_pkg::VALUE_W-1:0]         value_out,
    output logic signed [spl_pkg::PRIO_W-1:0]   priority_out,
    output logic [spl_pkg::COUNT_W-1:0]         count_out,
    output logic [spl_pkg::STATUS_W-1:0]        status
);

    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CNT_OUT_W = spl_pkg::COUNT_W;
    localparam int VAL_W     = spl_pkg::VALUE_W;
    localparam int RD_N      = (CAPACITY < 16) ? CAPACITY : 16;

    logic                               accept;
    logic                               full;
    logic                               do_insert;
    logic                               rd_ok;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    spl_pkg::spl_cell_ctrl_t            cell_ctrl;
    logic [63:0]                        in_wide;
    logic [PAYLOAD_BITS-1:0]            new_payload;
    logic [PAYLOAD_BITS-1:0]            cell_payload [CAPACITY];
    logic signed [spl_pkg::PRIO_W-1:0]  cell_prio    [CAPACITY];
    logic                               cell_ahead   [CAPACITY];
    logic [PAYLOAD_BITS-1:0]            rd_payload;
    logic signed [spl_pkg::PRIO_W-1:0]  rd_prio;
    logic [63:0]                        rd_wide;

    logic                               out_valid_reg;
    logic [VAL_W-1:0]                   value_reg;
    logic [VAL_W-1:0]                   value_next;
    logic signed [spl_pkg::PRIO_W-1:0]  prio_out_reg;
    logic signed [spl_pkg::PRIO_W-1:0]  prio_out_next;
    logic [CNT_OUT_W-1:0]               count_out_reg;
    logic [spl_pkg::STATUS_W-1:0]       status_reg;
    logic [spl_pkg::STATUS_W-1:0]       status_next;

    // Handshake: hold the input only while a result waits on a stalled output
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Insert control
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign do_insert = accept && (cmd == spl_pkg::CMD_INSERT) && !full;
    assign in_wide   = 64'(item_value);
    assign new_payload = in_wide[PAYLOAD_BITS-1:0];

    assign cell_ctrl.shift_en = do_insert;
    assign cell_ctrl.prio     = priority_in;

    // Row of cells, front at index zero
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_front
            spl_cell #(
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .clk          (clk),
                .ctrl         (cell_ctrl),
                .new_payload  (new_payload),
                .occupied     (count_reg != '0),
                .prev_ahead   (1'b1),
                .prev_payload (new_payload),
                .prev_prio    (priority_in),
                .ahead        (cell_ahead[i]),
                .payload      (cell_payload[i]),
                .prio         (cell_prio[i])
            );
        end
        else
        begin : g_rest
            spl_cell #(
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .clk          (clk),
                .ctrl         (cell_ctrl),
                .new_payload  (new_payload),
                .occupied     (32'(i) < 32'(count_reg)),
                .prev_ahead   (cell_ahead[i-1]),
                .prev_payload (cell_payload[i-1]),
                .prev_prio    (cell_prio[i-1]),
                .ahead        (cell_ahead[i]),
                .payload      (cell_payload[i]),
                .prio         (cell_prio[i])
            );
        end
    end

    // Select the entry at the read position among the addressable cells
    always_comb
    begin
        rd_payload = '0;
        rd_prio    = '0;
        for (int k = 0; k < RD_N; k++)
        begin
            if (32'(read_index) == k)
            begin
                rd_payload = cell_payload[k];
                rd_prio    = cell_prio[k];
            end
        end
    end

    assign rd_ok   = 32'(read_index) < 32'(count_reg);
    assign rd_wide = 64'(rd_payload);

    // Count after this transaction
    assign count_next = do_insert ? (count_reg + CNT_W'(1)) : count_reg;

    // Build the result
    always_comb
    begin
        value_next    = '0;
        prio_out_next = '0;
        status_next   = spl_pkg::ST_OK;
        if (cmd == spl_pkg::CMD_INSERT)
        begin
            if (full)
            begin
                status_next = spl_pkg::ST_FULL;
            end
        end
        else if (rd_ok)
        begin
            value_next    = rd_wide[VAL_W-1:0];
            prio_out_next = rd_prio;
        end
        else
        begin
            status_next = spl_pkg::ST_RANGE;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, captured on acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg     <= value_next;
            prio_out_reg  <= prio_out_next;
            count_out_reg <= CNT_OUT_W'(count_next);
            status_reg    <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign value_out    = value_reg;
    assign priority_out = prio_out_reg;
    assign count_out    = count_out_reg;
    assign status       = status_reg;

    // Checks
`include "sorted_priority_list_core_assert.svh"

    `SPL_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY))
    `SPL_ASSERT_SAME(a_full_flag, out_valid_reg && (status_reg == spl_pkg::ST_FULL), full)
    `SPL_ASSERT_NEXT(a_insert_count, do_insert, count_reg == CNT_W'($past(count_reg) + CNT_W'(1)))
    `SPL_ASSERT_SAME(a_front_order, count_reg >= CNT_W'(2), $signed(cell_prio[0]) >= $signed(cell_prio[1]))

endmodule
